FILE: rtl/core/mses_pkg.sv
// ----------------------------------------------------------------------------
// mses_pkg
// Shared types and constants for the match slot event scheduler.
// ----------------------------------------------------------------------------
package mses_pkg;

  localparam int DEF_SLOTS_PER_GROUP = 4;
  localparam int DEF_GROUP_COUNT     = 2;
  localparam int DEF_COUNTER_BITS    = 32;

  localparam int DELAY_W    = 32;
  localparam int SLOT_W     = 3;
  localparam int KIND_W     = 2;
  localparam int PRESCALE_W = 8;
  localparam int QDEPTH     = 2;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd24;

  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_SCHED = 1'b1
  } op_e_t;

  typedef struct packed {
    logic               opcode;
    logic [DELAY_W-1:0] delay;
    logic               repeat_req;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    op_e_t              op;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] reload;
  } q_item_t;

endpackage

FILE: rtl/core/mses_front.sv
// ----------------------------------------------------------------------------
// mses_front
// Input side: accepts beats, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mses_front import mses_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  q_item_t        mem [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  q_item_t        wr_item;
  logic           push;

  assign in_ready = count_r != QCW'(QDEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count_r != '0;
  assign q_item   = mem[rd_ptr_r];

  always_comb begin
    wr_item.op     = in_data.opcode ? OP_SCHED : OP_TICK;
    wr_item.delay  = in_data.delay;
    // one-shot events carry a zero reload
    wr_item.reload = in_data.repeat_req ? in_data.delay : '0;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/core/mses_back.sv
// ----------------------------------------------------------------------------
// mses_back
// Execution side: group counters, slot match registers and result output.
// ----------------------------------------------------------------------------
module mses_back import mses_pkg::*; #(
  parameter int SLOTS_PER_GROUP = DEF_SLOTS_PER_GROUP,
  parameter int GROUP_COUNT     = DEF_GROUP_COUNT,
  parameter int COUNTER_BITS    = DEF_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  q_item_t               q_item,
  output logic                  q_pop,
  input  logic [PRESCALE_W-1:0] prescale_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int TOTAL = SLOTS_PER_GROUP * GROUP_COUNT;
  localparam int NFW   = $clog2(TOTAL + 1);
  localparam int SIW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  logic [COUNTER_BITS-1:0] cnt_r   [GROUP_COUNT];
  logic [COUNTER_BITS-1:0] cnt_nxt [GROUP_COUNT];
  logic [COUNTER_BITS-1:0] cnt_inc [GROUP_COUNT];
  logic [COUNTER_BITS-1:0] base_cnt[GROUP_COUNT];
  logic [PRESCALE_W-1:0]   psc_r   [GROUP_COUNT];
  logic [PRESCALE_W-1:0]   psc_nxt [GROUP_COUNT];
  logic [GROUP_COUNT-1:0]  run_r, run_nxt;

  logic [COUNTER_BITS-1:0] dl_r  [TOTAL];
  logic [COUNTER_BITS-1:0] dl_nxt[TOTAL];
  logic [DELAY_W-1:0]      rl_r  [TOTAL];
  logic [DELAY_W-1:0]      rl_nxt[TOTAL];
  logic [TOTAL-1:0]        act_r, act_nxt;
  logic [TOTAL-1:0]        fire;
  logic [TOTAL-1:0]        pend_r, pend_nxt;
  logic [TOTAL-1:0]        low_oh;
  logic [SIW-1:0]          low_idx;
  logic [NFW-1:0]          nfree_r, nfree_nxt;

  logic [COUNTER_BITS-1:0] sel_base;
  logic [COUNTER_BITS-1:0] new_dl;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic                    out_load_ok;
  logic                    full;
  logic                    do_sched;
  logic                    do_tick;

  assign out_load_ok = !out_valid_r || out_ready;
  assign full        = nfree_r == NFW'(TOTAL);
  // next item waits until all fire results of the previous tick are out
  assign q_pop    = q_valid && (pend_r == '0) && (q_item.op == OP_TICK || out_load_ok);
  assign do_sched = q_pop && q_item.op == OP_SCHED;
  assign do_tick  = q_pop && q_item.op == OP_TICK;

  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      cnt_inc[g]  = cnt_r[g] + 1'b1;
      base_cnt[g] = run_r[g] ? cnt_r[g] : '0;
    end
  end

  always_comb begin
    sel_base = '0;
    for (int i = 0; i < TOTAL; i++) begin
      if (nfree_r == NFW'(i)) begin
        sel_base = base_cnt[i / SLOTS_PER_GROUP];
      end
    end
  end

  assign new_dl = sel_base + COUNTER_BITS'(q_item.delay);

  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      cnt_nxt[g] = cnt_r[g];
      psc_nxt[g] = psc_r[g];
    end
    run_nxt = run_r;
    for (int i = 0; i < TOTAL; i++) begin
      dl_nxt[i] = dl_r[i];
      rl_nxt[i] = rl_r[i];
    end
    act_nxt   = act_r;
    nfree_nxt = nfree_r;
    fire      = '0;

    if (do_sched && !full) begin
      for (int i = 0; i < TOTAL; i++) begin
        if (nfree_r == NFW'(i)) begin
          dl_nxt[i]  = new_dl;
          rl_nxt[i]  = q_item.reload;
          act_nxt[i] = 1'b1;
          if (!run_r[i / SLOTS_PER_GROUP]) begin
            run_nxt[i / SLOTS_PER_GROUP] = 1'b1;
            cnt_nxt[i / SLOTS_PER_GROUP] = '0;
            psc_nxt[i / SLOTS_PER_GROUP] = '0;
          end
        end
      end
      nfree_nxt = nfree_r + 1'b1;
    end

    if (do_tick) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        if (run_r[g]) begin
          // at or above the limit counts as a wrap
          if (psc_r[g] >= prescale_limit) begin
            psc_nxt[g] = '0;
            cnt_nxt[g] = cnt_inc[g];
            for (int j = 0; j < SLOTS_PER_GROUP; j++) begin
              if (act_r[g*SLOTS_PER_GROUP+j] &&
                  dl_r[g*SLOTS_PER_GROUP+j] == cnt_inc[g]) begin
                fire[g*SLOTS_PER_GROUP+j] = 1'b1;
                // deadline equals new count here, so re-arm off the deadline
                dl_nxt[g*SLOTS_PER_GROUP+j] = dl_r[g*SLOTS_PER_GROUP+j] +
                                              COUNTER_BITS'(rl_r[g*SLOTS_PER_GROUP+j]);
                if (rl_r[g*SLOTS_PER_GROUP+j] == '0) begin
                  act_nxt[g*SLOTS_PER_GROUP+j] = 1'b0;
                end
              end
            end
          end else begin
            psc_nxt[g] = psc_r[g] + 1'b1;
          end
        end
      end
    end
  end

  // lowest pending fire goes out first
  always_comb begin
    low_oh  = pend_r & (~pend_r + 1'b1);
    low_idx = '0;
    for (int i = 0; i < TOTAL; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | SIW'(i);
      end
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pend_nxt      = pend_r;
    if (do_sched) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt.kind = full ? KIND_FULL : KIND_ASSIGN;
      out_data_nxt.slot = full ? '0 : SLOT_W'(nfree_r);
      out_data_nxt.last = 1'b1;
    end else if (do_tick) begin
      pend_nxt = fire;
    end else if (pend_r != '0 && out_load_ok) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt.kind = KIND_FIRE;
      out_data_nxt.slot = SLOT_W'(low_idx);
      out_data_nxt.last = (pend_r & ~low_oh) == '0;
      pend_nxt          = pend_r & ~low_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        cnt_r[g] <= '0;
        psc_r[g] <= '0;
      end
      run_r       <= '0;
      act_r       <= '0;
      nfree_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        cnt_r[g] <= cnt_nxt[g];
        psc_r[g] <= psc_nxt[g];
      end
      run_r       <= run_nxt;
      act_r       <= act_nxt;
      nfree_r     <= nfree_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOTAL; i++) begin
      dl_r[i] <= dl_nxt[i];
      rl_r[i] <= rl_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/match_slot_event_scheduler_top.sv
// ----------------------------------------------------------------------------
// match_slot_event_scheduler_top
// Event slots in groups, each group timed by its own prescaled counter.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) are either one clock tick or a schedule
// request. A request takes the next free slot and returns one beat: slot
// assigned, or refused when all slots are taken. A tick steps every running
// group's prescaler and, on wrap, its counter; each matching slot returns a
// fire beat, in ascending slot order, the last one flagged by last.
// Beats enter a two-entry queue; the execution side takes one item a cycle
// when it has no fire beats left to send and, for a request, the output
// register can load. A tick first steps the counters, then its fire beats
// pass one at a time through the output register; a request's result beat
// is loaded into the output register when the request leaves the queue.
// cfg_we writes prescale_limit (ticks minus one per count) at once.
// Reset: groups stopped, slots free and inactive, prescale_limit 24.
// A stalled receiver holds the output register; once a request or fire beat
// waits behind it, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module match_slot_event_scheduler_top import mses_pkg::*; #(
  parameter int SLOTS_PER_GROUP = DEF_SLOTS_PER_GROUP,
  parameter int GROUP_COUNT     = DEF_GROUP_COUNT,
  parameter int COUNTER_BITS    = DEF_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [PRESCALE_W-1:0] cfg_wdata
);

  logic [PRESCALE_W-1:0] prescale_limit_r;
  logic                  q_valid;
  q_item_t               q_item;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_limit_r <= PRESCALE_RESET;
    end else if (cfg_we) begin
      prescale_limit_r <= cfg_wdata;
    end
  end

  mses_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mses_back #(
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
    .GROUP_COUNT     (GROUP_COUNT),
    .COUNTER_BITS    (COUNTER_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .prescale_limit (prescale_limit_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

FILE: rtl/core/mses_checker.sv
// ----------------------------------------------------------------------------
// mses_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mses_checker import mses_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data
);

  // held beat stays put while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_ASSIGN || out_data.kind == KIND_FIRE ||
                   out_data.kind == KIND_FULL))
    else $error("unknown result kind");

  a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_FULL |-> out_data.slot == '0 && out_data.last)
    else $error("refused beat must carry slot zero and last");

  a_assign_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ASSIGN |-> out_data.last)
    else $error("assign beat must be last");

  a_reset_ready: assert property (@(posedge clk)
    $rose(rst_n) |-> in_ready && !out_valid)
    else $error("queue not empty after reset");

endmodule

bind match_slot_event_scheduler_top mses_checker u_mses_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the match slot event scheduler against a cycle-free predictor of its
// slots, group counters and prescalers. Directed beats arm every slot kind and
// step the prescaler across limit changes. Random phases then mix ticks and
// requests under varied prescale limits, mostly with bursty idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import mses_pkg::*;

  localparam int SPG            = DEF_SLOTS_PER_GROUP;
  localparam int GROUPS         = DEF_GROUP_COUNT;
  localparam int SLOTS          = SPG * GROUPS;
  localparam int SETTLE         = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BEATS    = 36;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [PRESCALE_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [DEF_COUNTER_BITS-1:0] grp_count  [GROUPS];
  logic [PRESCALE_W-1:0]       grp_presc  [GROUPS];
  bit                          grp_run    [GROUPS];
  logic [DEF_COUNTER_BITS-1:0] slot_due   [SLOTS];
  logic [DELAY_W-1:0]          slot_period[SLOTS];
  bit                          slot_armed [SLOTS];
  int unsigned                 next_slot;
  logic [PRESCALE_W-1:0]       presc_limit;

  in_item_t  cmd_q[$];         // beats waiting to be driven
  out_item_t sched_beats_q[$]; // assign/fire/refuse beats still to come

  bit idle_on = 1'b0;
  int in_hold = 0;
  int out_hold = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  match_slot_event_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic sched_clear();
    for (int g = 0; g < GROUPS; g++) begin
      grp_count[g] = '0;
      grp_presc[g] = '0;
      grp_run[g]   = 1'b0;
    end
    for (int s = 0; s < SLOTS; s++) begin
      slot_due[s]    = '0;
      slot_period[s] = '0;
      slot_armed[s]  = 1'b0;
    end
    next_slot   = 0;
    presc_limit = PRESCALE_RESET;
  endtask

  // Works out the beats one accepted item causes and queues them.
  task automatic sched_step(input in_item_t it);
    out_item_t   res[$];
    out_item_t   b;
    int unsigned s;
    int          g;
    if (it.opcode == OP_SCHED) begin
      if (next_slot < SLOTS) begin
        s = next_slot;
        g = s / SPG;
        if (!grp_run[g]) begin
          grp_run[g]   = 1'b1;
          grp_count[g] = '0;
          grp_presc[g] = '0;
        end
        slot_due[s]    = grp_count[g] + it.delay;
        slot_period[s] = it.repeat_req ? it.delay : '0;
        slot_armed[s]  = 1'b1;
        next_slot      = s + 1;
        b.kind = KIND_ASSIGN;
        b.slot = SLOT_W'(s);
      end else begin
        b.kind = KIND_FULL;
        b.slot = '0;
      end
      b.last = 1'b0;
      res.push_back(b);
    end else begin
      for (g = 0; g < GROUPS; g++) begin
        if (!grp_run[g]) continue;
        // a prescaler left above a lowered limit wraps as well
        if (grp_presc[g] >= presc_limit) begin
          grp_presc[g] = '0;
          grp_count[g] = grp_count[g] + 1'b1;
          for (int j = 0; j < SPG; j++) begin
            s = g * SPG + j;
            if (slot_armed[s] && slot_due[s] == grp_count[g]) begin
              slot_due[s] = grp_count[g] + slot_period[s];
              if (slot_period[s] == '0) slot_armed[s] = 1'b0;
              b.kind = KIND_FIRE;
              b.slot = SLOT_W'(s);
              b.last = 1'b0;
              res.push_back(b);
            end
          end
        end else begin
          grp_presc[g] = grp_presc[g] + 1'b1;
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) sched_beats_q.push_back(res[k]);
  endtask

  function automatic in_item_t mk_item(input op_e_t op, input logic [DELAY_W-1:0] dly,
                                       input logic rep);
    in_item_t it;
    it.opcode     = op;
    it.delay      = dly;
    it.repeat_req = rep;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) sched_step(in_data);
      if (in_hold > 0) begin
        in_hold--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_hold = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_hold = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sched_beats_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d slot %0d last %0b",
                                out_data.kind, out_data.slot, out_data.last));
      end else begin
        want = sched_beats_q.pop_front();
        if (out_data.kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.slot !== want.slot)
          flag_mismatch($sformatf("slot %0d, want %0d", out_data.slot, want.slot));
        if (out_data.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
      end
    end
  end

  // watchdog: cycles with no beat moved on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all beats driven and answered, then room for result-free ticks in flight
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || sched_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_prescale(input logic [PRESCALE_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    presc_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    logic [PRESCALE_W-1:0] lim;
    logic [DELAY_W-1:0]    dly;
    sched_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default limit: tick on stopped groups, then fill group 0
    idle_on = 1'b1;
    cmd_q.push_back(mk_item(OP_TICK, 32'hFFFF_FFFF, 1'b1));
    cmd_q.push_back(mk_item(OP_SCHED, 32'h0, 1'b0));         // zero delay
    cmd_q.push_back(mk_item(OP_SCHED, 32'hFFFF_FFFF, 1'b1)); // deadline at the counter maximum
    cmd_q.push_back(mk_item(OP_SCHED, 32'd1, 1'b1));
    cmd_q.push_back(mk_item(OP_SCHED, 32'd2, 1'b1));
    repeat (3) cmd_q.push_back(mk_item(OP_TICK, 32'h0, 1'b0));
    wait_idle();

    // limit lowered under the running prescaler
    set_prescale(8'd0);
    repeat (4) cmd_q.push_back(mk_item(OP_TICK, $urandom, 1'($urandom)));
    cmd_q.push_back(mk_item(OP_SCHED, 32'd3, 1'b0));         // group 1 starts
    repeat (6) cmd_q.push_back(mk_item(OP_TICK, $urandom, 1'($urandom)));
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       lim = 8'd255;
        1:       lim = 8'd0;
        default: lim = ($urandom_range(0, 7) == 0) ? PRESCALE_W'($urandom)
                                                    : PRESCALE_W'($urandom_range(0, 3));
      endcase
      idle_on = (ph != 3) && (ph != RAND_PHASES - 1);
      set_prescale(lim);
      repeat (PHASE_BEATS) begin
        dly = ($urandom_range(0, 9) < 7) ? DELAY_W'($urandom_range(1, 8)) : DELAY_W'($urandom);
        if ($urandom_range(0, 99) < 12)
          cmd_q.push_back(mk_item(OP_SCHED, dly, 1'($urandom)));
        else
          cmd_q.push_back(mk_item(OP_TICK, dly, 1'($urandom)));
      end
      wait_idle();
    end

    if (mismatches == 0 && sched_beats_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
